// ===== rtl/brf_pkg.sv =====
// Package for the byte ring FIFO: widths, opcodes and beat payload types.
`timescale 1ns / 1ps
`default_nettype none
package brf_pkg;

   localparam int STORE_DEPTH_DEF = 256;
   localparam int SIZE_W          = 9;
   localparam int BYTE_W          = 8;
   localparam int OVERRUN_W       = 32;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_GET   = 2'd1,
      OP_FLUSH = 2'd2,
      OP_NOP   = 2'd3
   } brf_op_type;

   typedef enum logic {
      ST_DONE    = 1'b0,
      ST_REFUSED = 1'b1
   } brf_status_type;

   typedef struct packed {
      brf_op_type        opcode;
      logic [BYTE_W-1:0] put_byte;
   } brf_req_type;

   typedef struct packed {
      brf_status_type       status;
      logic [BYTE_W-1:0]    got_byte;
      logic [SIZE_W-1:0]    fill_count;
      logic [SIZE_W-1:0]    free_space;
      logic                 is_empty;
      logic                 is_full;
      logic [OVERRUN_W-1:0] overrun_total;
   } brf_rsp_type;

endpackage
`default_nettype wire

// ===== rtl/brf_channels.sv =====
// Valid/ready channel interfaces for request, response and size register beats.
`timescale 1ns / 1ps
`default_nettype none
interface brf_req_if import brf_pkg::*; ();
   logic        valid;
   logic        ready;
   brf_req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface brf_rsp_if import brf_pkg::*; ();
   logic        valid;
   logic        ready;
   brf_rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface brf_csr_if import brf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/byte_ring_fifo_top.sv =====
// Byte ring FIFO top level: index and count control around one byte store memory.
`timescale 1ns / 1ps
`default_nettype none
// Each request beat is one operation (put, get, flush, no-op) and yields one
// response beat in the cycle after it is taken. Requests are taken every cycle
// while the response register is empty or being drained and no size beat is
// offered, so the block sustains one operation per cycle; the response and the
// byte store memory read are registered. The usable size is the size register
// clamped to the range one to STORE_DEPTH; writing it empties the FIFO but
// keeps the overrun count. The size port is always ready; the user must write
// it only while no operation is in flight, which the block does not enforce.
// The store holds no reset state; only entries already written are read.
module byte_ring_fifo_top
   import brf_pkg::*;
#(
   parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
   input  wire         clock,
   input  wire         reset,
   brf_req_if.sink     req_bus,
   brf_rsp_if.source   rsp_bus,
   brf_csr_if.sink     csr_bus
);

   localparam int IW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);

   logic [BYTE_W-1:0]    store_mem [STORE_DEPTH];
   logic [BYTE_W-1:0]    rdata_ff;

   logic [SIZE_W-1:0]    size_ff,    size_in;
   logic [IW-1:0]        ridx_ff,    ridx_in;
   logic [IW-1:0]        widx_ff,    widx_in;
   logic [CW-1:0]        held_ff,    held_in;
   logic [OVERRUN_W-1:0] overrun_ff, overrun_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   brf_rsp_type          rsp_ff,     rsp_in;
   logic                 got_ok_ff,  got_ok_in;

   logic [CW-1:0]        eff_size;
   logic [CW-1:0]        ridx_inc;
   logic [CW-1:0]        widx_inc;
   logic                 req_take;
   logic                 csr_take;
   logic                 wr_en;
   logic                 rd_en;

   assign req_bus.ready = (!rsp_valid_ff || rsp_bus.ready) && !csr_bus.valid;
   assign csr_bus.ready = 1'b1;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_take      = csr_bus.valid;

   always_comb begin
      if (size_ff == '0) begin
         eff_size = CW'(1);
      end else if (32'(size_ff) > 32'(STORE_DEPTH)) begin
         eff_size = CW'(STORE_DEPTH);
      end else begin
         eff_size = CW'(size_ff);
      end
   end

   assign ridx_inc = CW'(ridx_ff) + CW'(1);
   assign widx_inc = CW'(widx_ff) + CW'(1);

   always_comb begin
      size_in      = size_ff;
      ridx_in      = ridx_ff;
      widx_in      = widx_ff;
      held_in      = held_ff;
      overrun_in   = overrun_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      got_ok_in    = got_ok_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_take) begin
         size_in = csr_bus.data;
         ridx_in = '0;
         widx_in = '0;
         held_in = '0;
      end else if (req_take) begin
         rsp_in.status = ST_DONE;
         got_ok_in     = 1'b0;
         unique case (req_bus.data.opcode)
            OP_PUT: begin
               if (held_ff >= eff_size) begin
                  overrun_in    = overrun_ff + OVERRUN_W'(1);
                  rsp_in.status = ST_REFUSED;
               end else begin
                  wr_en   = 1'b1;
                  widx_in = (widx_inc >= eff_size) ? '0 : IW'(widx_inc);
                  held_in = held_ff + CW'(1);
               end
            end
            OP_GET: begin
               if (held_ff == '0) begin
                  rsp_in.status = ST_REFUSED;
               end else begin
                  rd_en     = 1'b1;
                  got_ok_in = 1'b1;
                  ridx_in   = (ridx_inc >= eff_size) ? '0 : IW'(ridx_inc);
                  held_in   = held_ff - CW'(1);
               end
            end
            OP_FLUSH: begin
               ridx_in = '0;
               widx_in = '0;
               held_in = '0;
            end
            OP_NOP: begin
            end
            default: begin
            end
         endcase
         rsp_in.got_byte      = '0;
         rsp_in.fill_count    = SIZE_W'(held_in);
         rsp_in.free_space    = SIZE_W'(eff_size - held_in);
         rsp_in.is_empty      = (held_in == '0);
         rsp_in.is_full       = (held_in >= eff_size);
         rsp_in.overrun_total = overrun_in;
         rsp_valid_in         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[widx_ff] <= req_bus.data.put_byte;
      end
      if (rd_en) begin
         rdata_ff <= store_mem[ridx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= SIZE_RESET;
         ridx_ff      <= '0;
         widx_ff      <= '0;
         held_ff      <= '0;
         overrun_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         got_ok_ff    <= 1'b0;
      end else begin
         size_ff      <= size_in;
         ridx_ff      <= ridx_in;
         widx_ff      <= widx_in;
         held_ff      <= held_in;
         overrun_ff   <= overrun_in;
         rsp_valid_ff <= rsp_valid_in;
         got_ok_ff    <= got_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_comb begin
      rsp_bus.data = rsp_ff;
      if (got_ok_ff) begin
         rsp_bus.data.got_byte = rdata_ff;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;

endmodule
`default_nettype wire
